// ----- rtl/core/ppp_pkg.sv -----
// Package for the point to pixel projection block.
// Holds the item types, the register map and the arithmetic widths.
// Depends on nothing.
package ppp_pkg;

	localparam int COORD_W = 32;
	localparam int SUM_W = 67;
	localparam int DVD_W = SUM_W + 2;
	localparam int DVS_W = SUM_W + 1;
	localparam int Q_W = 17;
	localparam int CMP_W = DVS_W + Q_W;
	localparam int DIM_W = 15;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		REG_ROW0_A = 3'd0,
		REG_ROW0_B = 3'd1,
		REG_ROW1_A = 3'd2,
		REG_ROW1_B = 3'd3,
		REG_ROW2_A = 3'd4,
		REG_ROW2_B = 3'd5,
		REG_WIDTH  = 3'd6,
		REG_HEIGHT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pixel_u;
		logic signed [15:0] pixel_v;
		logic               inside_image;
		logic               zero_depth;
	} out_item_t;

	// Coefficient set: per row x, y, z coefficient and offset.
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic signed [COORD_W-1:0] off;
	} row_coef_t;

	typedef row_coef_t [2:0] coef_set_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic [1:0][SUM_W-1:0] num_abs;
		logic [1:0]            num_neg;
		logic [SUM_W-1:0]      den_abs;
		logic                  den_neg;
		logic                  zero;
	} mid_item_t;

endpackage

// ----- rtl/core/point_to_pixel_projection.sv -----
// Top level of the point to pixel projection block.
// Holds the register file and joins front, back and queues; depends on ppp_pkg.
//
// Each point item (x, y, z in signed Q16.16) is multiplied through a 3x4 matrix
// held in six 64-bit registers; rows 0 and 1 are divided by row 2, rounded half
// away from zero and saturated to signed 16-bit pixel u and v, with a flag for
// 0<u<width, 0<v<height and a flag for a zero depth sum (then u=v=0). The block
// accepts one item per clock cycle while full is low and yields one result per
// cycle while popped and not empty. An item passes five front stages (input,
// the nine 32x32 multipliers, two adder stages, magnitude and sign), the middle
// queue and nineteen back stages: entry, saturation check and the restoring
// divider stages that each produce one quotient bit for u and v side by side.
// Up to four results wait in the output queue; when it fills the back stalls,
// the middle queue fills, then full rises. The user must write configuration
// over APB at byte address 8*i only while the block is idle; nothing checks this.
module point_to_pixel_projection import ppp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        push,
	input  in_item_t    point,
	output logic        full,
	input  logic        pop,
	output out_item_t   pixel,
	output logic        empty
);
	logic [5:0][63:0] coef_q;
	logic [DIM_W-1:0] width_q, height_q;
	coef_set_t coef;
	reg_idx_t idx;
	logic wr;

	logic mid_valid, mid_full, mid_empty, mid_pop;
	mid_item_t mid_in, mid_out;
	logic res_valid, res_full;
	out_item_t res_item;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[5:3]);
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			width_q <= DIM_W'(1920);
			height_q <= DIM_W'(1080);
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:  width_q <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    coef_q[idx] <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = 64'(width_q);
			REG_HEIGHT: prdata = 64'(height_q);
			default:    prdata = coef_q[idx];
		endcase
		// Register a holds x and y coefficients, register b holds z and offset.
		for (int r = 0; r < 3; r++) begin
			coef[r].cx = coef_q[2*r][63:32];
			coef[r].cy = coef_q[2*r][31:0];
			coef[r].cz = coef_q[2*r+1][63:32];
			coef[r].off = coef_q[2*r+1][31:0];
		end
	end

	ppp_front u_front (
		.clk, .arst_n, .coef, .push, .point, .full,
		.mid_valid, .mid_item(mid_in), .mid_full
	);

	ppp_queue #(.WIDTH($bits(mid_item_t)), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
		.clk, .arst_n, .wr_en(mid_valid), .wr_data(mid_in), .rd_en(mid_pop),
		.rd_data(mid_out), .full(mid_full), .empty(mid_empty)
	);

	ppp_back u_back (
		.clk, .arst_n, .image_width(width_q), .image_height(height_q),
		.mid_empty, .mid_item(mid_out), .mid_pop,
		.res_valid, .res_item, .res_full
	);

	ppp_queue #(.WIDTH($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_out_queue (
		.clk, .arst_n, .wr_en(res_valid), .wr_data(res_item), .rd_en(pop),
		.rd_data(pixel), .full(res_full), .empty(empty)
	);

	// A zero depth result carries no pixel.
	a_zero_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.zero_depth |->
		res_item.pixel_u == 16'sd0 && res_item.pixel_v == 16'sd0 && !res_item.inside_image)
		else $error("zero depth result with pixel data");

	// An inside flag needs strictly positive coordinates.
	a_inside_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.inside_image |->
		res_item.pixel_u > 16'sd0 && res_item.pixel_v > 16'sd0)
		else $error("inside flag on non-positive pixel");

	// The back never pops an empty middle queue.
	a_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("middle queue popped while empty");

	// A stalled front holds its classified item until the queue has room.
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mid_valid && mid_full |=> mid_valid && $stable(mid_in))
		else $error("front item lost during stall");
endmodule

// ----- rtl/core/ppp_queue.sv -----
// Small first-in first-out queue of register entries.
// Depends on nothing; used between the front and back and at the output.
module ppp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr, do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end
endmodule

// ----- rtl/core/ppp_front.sv -----
// Front part: takes points, forms the three row sums and classifies them.
// Depends on ppp_pkg.
module ppp_front import ppp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  coef_set_t coef,
	input  logic      push,
	input  in_item_t  point,
	output logic      full,
	output logic      mid_valid,
	output mid_item_t mid_item,
	input  logic      mid_full
);
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	in_item_t pt_s1;
	logic signed [2:0][2:0][63:0] prod_s2;
	logic signed [SUM_W-1:0] off_s2 [3];
	logic signed [SUM_W-1:0] pa_s3 [3], pb_s3 [3], sum_s4 [3];
	mid_item_t item_s5;

	assign en = !(v_s5 && mid_full);
	assign full = !en;
	assign mid_valid = v_s5;
	assign mid_item = item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= point;
			for (int r = 0; r < 3; r++) begin
				prod_s2[r][0] <= coef[r].cx * pt_s1.point_x;
				prod_s2[r][1] <= coef[r].cy * pt_s1.point_y;
				prod_s2[r][2] <= coef[r].cz * pt_s1.point_z;
				off_s2[r] <= SUM_W'(coef[r].off) <<< 16;
				// Elements of a packed array read as unsigned, so the products
				// are marked signed again before they are extended.
				pa_s3[r] <= SUM_W'($signed(prod_s2[r][0])) + SUM_W'($signed(prod_s2[r][1]));
				pb_s3[r] <= SUM_W'($signed(prod_s2[r][2])) + off_s2[r];
				sum_s4[r] <= pa_s3[r] + pb_s3[r];
			end
			for (int r = 0; r < 2; r++) begin
				item_s5.num_neg[r] <= sum_s4[r][SUM_W-1];
				item_s5.num_abs[r] <= sum_s4[r][SUM_W-1] ? -sum_s4[r] : sum_s4[r];
			end
			item_s5.den_neg <= sum_s4[2][SUM_W-1];
			item_s5.den_abs <= sum_s4[2][SUM_W-1] ? -sum_s4[2] : sum_s4[2];
			item_s5.zero <= (sum_s4[2] == '0);
		end
	end
endmodule

// ----- rtl/core/ppp_back.sv -----
// Back part: restoring division pipeline, rounding, saturation, inside test.
// Depends on ppp_pkg.
module ppp_back import ppp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] image_width,
	input  logic [DIM_W-1:0] image_height,
	input  logic             mid_empty,
	input  mid_item_t        mid_item,
	output logic             mid_pop,
	output logic             res_valid,
	output out_item_t        res_item,
	input  logic             res_full
);
	typedef struct packed {
		logic [1:0][DVD_W-1:0] rem;
		logic [DVS_W-1:0]      dvs;
		logic [1:0][Q_W-1:0]   q;
		logic [1:0]            sat;
		logic [1:0]            neg;
		logic                  zero;
	} div_stage_t;

	logic en;
	logic v_s0;
	logic [Q_W:0] v_st;
	div_stage_t ent_s0;
	div_stage_t st_s [Q_W+1];
	div_stage_t ent_nx;
	div_stage_t st_nx [Q_W+1];
	logic [1:0][Q_W-1:0] qf;
	logic [1:0][Q_W-1:0] lim;
	logic [1:0][15:0] pix;

	assign en = !(v_st[Q_W] && res_full);
	assign mid_pop = en && !mid_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_st <= '0;
		end else if (en) begin
			v_s0 <= !mid_empty;
			v_st <= {v_st[Q_W-1:0], v_s0};
		end
	end

	always_comb begin
		ent_nx = '0;
		for (int l = 0; l < 2; l++) begin
			ent_nx.rem[l] = {1'b0, mid_item.num_abs[l], 1'b0} + DVD_W'(mid_item.den_abs);
			ent_nx.neg[l] = mid_item.num_neg[l] ^ mid_item.den_neg;
		end
		ent_nx.dvs = {mid_item.den_abs, 1'b0};
		ent_nx.zero = mid_item.zero;
		// Quotients of 2^17 or more saturate; the steps below then do not matter.
		st_nx[0] = ent_s0;
		for (int l = 0; l < 2; l++)
			st_nx[0].sat[l] = CMP_W'(ent_s0.rem[l]) >= (CMP_W'(ent_s0.dvs) << Q_W);
		for (int j = 0; j < Q_W; j++) begin
			st_nx[j+1] = st_s[j];
			for (int l = 0; l < 2; l++) begin
				if (CMP_W'(st_s[j].rem[l]) >= (CMP_W'(st_s[j].dvs) << (Q_W - 1 - j))) begin
					st_nx[j+1].rem[l] = DVD_W'(CMP_W'(st_s[j].rem[l])
						- (CMP_W'(st_s[j].dvs) << (Q_W - 1 - j)));
					st_nx[j+1].q[l][Q_W-1-j] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s0 <= ent_nx;
			for (int j = 0; j <= Q_W; j++)
				st_s[j] <= st_nx[j];
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			lim[l] = st_s[Q_W].neg[l] ? Q_W'(32768) : Q_W'(32767);
			qf[l] = (st_s[Q_W].sat[l] || st_s[Q_W].q[l] > lim[l]) ? lim[l] : st_s[Q_W].q[l];
			pix[l] = st_s[Q_W].zero ? '0 :
				(st_s[Q_W].neg[l] ? 16'(-qf[l]) : qf[l][15:0]);
		end
		res_valid = v_st[Q_W];
		res_item.pixel_u = $signed(pix[0]);
		res_item.pixel_v = $signed(pix[1]);
		res_item.zero_depth = st_s[Q_W].zero;
		res_item.inside_image = !st_s[Q_W].zero
			&& ($signed(pix[0]) > 16'sd0) && ($signed(pix[1]) > 16'sd0)
			&& ($signed(pix[0]) < $signed({1'b0, image_width}))
			&& ($signed(pix[1]) < $signed({1'b0, image_height}));
	end
endmodule
